// ===== rtl/core/swrv_pkg.sv =====
// Shared constants and types for the LIFO stack with delete-by-value.
package swrv_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int COUNT_OUT_W = 5;

    localparam int IN_TDATA_W  = 40;  // 2 + 32 bits, padded to bytes
    localparam int OUT_TDATA_W = 40;  // 32 + 1 + 1 + 5 bits, padded to bytes

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // per-cycle command broadcast along the row of cells
    typedef struct packed {
        logic push_shift;  // every entry moves one place down, new top enters
        logic pop_shift;   // every entry moves one place up
        logic remove_en;   // entries at and below the first match move up
    } t_cell_ctl;

    // status the row reports back to the top level
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;         // some valid entry matched the search value
    } t_row_stat;

endpackage

// ===== rtl/core/swrv_cell.sv =====
// One storage cell of the stack row: value, valid flag and match chain link.
module swrv_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swrv_pkg::t_cell_ctl               i_ctl,
    input  logic signed [swrv_pkg::DATA_W-1:0] i_value,
    input  logic signed [swrv_pkg::DATA_W-1:0] i_up_data,
    input  logic                              i_up_valid,
    input  logic signed [swrv_pkg::DATA_W-1:0] i_dn_data,
    input  logic                              i_dn_valid,
    input  logic                              i_hit,
    output logic signed [swrv_pkg::DATA_W-1:0] o_data,
    output logic                              o_valid,
    output logic                              o_hit
);

    logic signed [swrv_pkg::DATA_W-1:0] r_data;
    logic signed [swrv_pkg::DATA_W-1:0] n_data;
    logic                               r_valid;
    logic                               n_valid;
    logic                               match;

    assign match = r_valid && (r_data == i_value);
    assign o_hit = i_hit || match;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.push_shift) begin
            n_data  = i_up_data;
            n_valid = i_up_valid;
        end else if (i_ctl.pop_shift || (i_ctl.remove_en && o_hit)) begin
            n_data  = i_dn_data;
            n_valid = i_dn_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ===== rtl/core/swrv_row.sv =====
// Row of stack cells, top of stack in cell 0, with the match chain.
module swrv_row (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swrv_pkg::t_cell_ctl               i_ctl,
    input  logic signed [swrv_pkg::DATA_W-1:0] i_value,
    output logic signed [swrv_pkg::DATA_W-1:0] o_top_data,
    output swrv_pkg::t_row_stat               o_stat
);

    logic signed [swrv_pkg::DATA_W-1:0] data  [swrv_pkg::STACK_DEPTH];
    logic                               valid [swrv_pkg::STACK_DEPTH];
    logic [swrv_pkg::STACK_DEPTH:0]     hit;

    assign hit[0] = 1'b0;

    for (genvar g = 0; g < swrv_pkg::STACK_DEPTH; g++) begin : g_cell
        logic signed [swrv_pkg::DATA_W-1:0] up_data;
        logic                               up_valid;
        logic signed [swrv_pkg::DATA_W-1:0] dn_data;
        logic                               dn_valid;

        if (g == 0) begin : g_top
            assign up_data  = i_value;
            assign up_valid = 1'b1;
        end else begin : g_mid_up
            assign up_data  = data[g-1];
            assign up_valid = valid[g-1];
        end

        if (g == swrv_pkg::STACK_DEPTH - 1) begin : g_bottom
            assign dn_data  = '0;
            assign dn_valid = 1'b0;
        end else begin : g_mid_dn
            assign dn_data  = data[g+1];
            assign dn_valid = valid[g+1];
        end

        swrv_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_value    (i_value),
            .i_up_data  (up_data),
            .i_up_valid (up_valid),
            .i_dn_data  (dn_data),
            .i_dn_valid (dn_valid),
            .i_hit      (hit[g]),
            .o_data     (data[g]),
            .o_valid    (valid[g]),
            .o_hit      (hit[g+1])
        );
    end

    assign o_top_data   = data[0];
    assign o_stat.empty = !valid[0];
    assign o_stat.full  = valid[swrv_pkg::STACK_DEPTH-1];
    assign o_stat.hit   = hit[swrv_pkg::STACK_DEPTH];

endmodule

// ===== rtl/core/stack_with_remove_by_value.sv =====
// Top level: LIFO stack of signed words with push, pop and delete-by-value.
//
// Input stream (s_axis_*): one word per operation; tdata holds opcode
// (push, pop, remove first match from the top) and the operand value.
// Output stream (m_axis_*): exactly one result word per input word, in
// order: popped value, ok flag, full-drop flag and the entry count after
// the operation (count taken modulo 32).
// Output: the result is registered and shows on m_axis in the cycle after
// the input word is taken. Throughput: one word per cycle unless m_axis
// stalls; every cell of the row compares and shifts in the same cycle,
// with the first-match search rippling through the cells from the top.
// Stall: the output register holds its word until taken; a new input word
// is taken in the cycle the held word leaves, so back-pressure reaches
// s_axis_tready only when the output register is full and not drained.
// Reset (i_rst_n low, synchronous): all cells are marked empty, the count
// goes to zero and the output register is emptied. Stored values are not
// cleared; an empty cell is never read.
module stack_with_remove_by_value (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tdata: [1:0] opcode, [33:2] operand_value, [39:34] zero
    input  logic [swrv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [31:0] popped_value, [32] ok, [33] full_drop,
    //        [38:34] entry_count, [39] zero
    output logic [swrv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready
);

    swrv_pkg::t_op                      op;
    logic signed [swrv_pkg::DATA_W-1:0] value;
    logic                               in_acc;

    swrv_pkg::t_cell_ctl                ctl;
    swrv_pkg::t_row_stat                stat;
    logic signed [swrv_pkg::DATA_W-1:0] top_data;

    logic [swrv_pkg::CNT_W-1:0]         r_count;
    logic [swrv_pkg::CNT_W-1:0]         n_count;

    logic                               r_out_valid;
    logic [swrv_pkg::OUT_TDATA_W-1:0]   r_out_data;
    logic [swrv_pkg::OUT_TDATA_W-1:0]   n_out_data;

    logic signed [swrv_pkg::DATA_W-1:0] res_popped;
    logic                               res_ok;
    logic                               res_drop;
    logic [swrv_pkg::CNT_W+swrv_pkg::COUNT_OUT_W-1:0] count_wide;

    assign op     = swrv_pkg::t_op'(s_axis_tdata[1:0]);
    assign value  = s_axis_tdata[swrv_pkg::DATA_W+1:2];

    // output register frees itself when its word is taken
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // decode the operation into row commands and the result fields
    always_comb begin
        ctl        = '0;
        res_popped = '0;
        res_ok     = 1'b0;
        res_drop   = 1'b0;
        n_count    = r_count;
        case (op)
            swrv_pkg::OP_PUSH: begin
                if (stat.full) begin
                    res_drop = 1'b1;
                end else begin
                    ctl.push_shift = in_acc;
                    res_ok         = 1'b1;
                    n_count        = r_count + swrv_pkg::CNT_W'(1);
                end
            end
            swrv_pkg::OP_POP: begin
                if (!stat.empty) begin
                    ctl.pop_shift = in_acc;
                    res_popped    = top_data;
                    res_ok        = 1'b1;
                    n_count       = r_count - swrv_pkg::CNT_W'(1);
                end
            end
            swrv_pkg::OP_REMOVE: begin
                ctl.remove_en = in_acc;
                if (stat.hit) begin
                    res_ok  = 1'b1;
                    n_count = r_count - swrv_pkg::CNT_W'(1);
                end
            end
            default: begin
                // unused opcode: no change, report the count
            end
        endcase
    end

    assign count_wide = {{swrv_pkg::COUNT_OUT_W{1'b0}}, n_count};

    always_comb begin
        n_out_data = '0;
        n_out_data[swrv_pkg::DATA_W-1:0] = res_popped;
        n_out_data[swrv_pkg::DATA_W]     = res_ok;
        n_out_data[swrv_pkg::DATA_W+1]   = res_drop;
        n_out_data[swrv_pkg::DATA_W+2+:swrv_pkg::COUNT_OUT_W] =
            count_wide[swrv_pkg::COUNT_OUT_W-1:0];
    end

    swrv_row u_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_value    (value),
        .o_top_data (top_data),
        .o_stat     (stat)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= n_out_data;
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count <= n_count;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tvalid = r_out_valid;

`ifndef SYNTHESIS
    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.empty == (r_count == '0))
        else $error("empty flag of row disagrees with count");

    a_full_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.full == (r_count == swrv_pkg::CNT_W'(swrv_pkg::STACK_DEPTH)))
        else $error("full flag of row disagrees with count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= swrv_pkg::CNT_W'(swrv_pkg::STACK_DEPTH))
        else $error("count beyond stack depth");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.push_shift, ctl.pop_shift, ctl.remove_en}))
        else $error("more than one row command at once");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the LIFO stack with push, pop and delete-by-value.
`timescale 1ns / 100ps

module testbench;

    // Unused opcode: the block must answer with a no-op result.
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int RAND_WORDS_PER_PHASE = 634;
    localparam int DRAIN_CYCLES         = 8;

    // One result word, unpacked from m_axis_tdata.
    typedef struct packed {
        logic [31:0] popped;
        logic        ok;
        logic        drop;
        logic [4:0]  count;
    } t_result;

    // One row of the directed table. Where hand_checked is set, want is the
    // result written in by hand; otherwise the stack predictor supplies it.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] val;
        logic [4:0]  reps;
        logic        hand_checked;
        t_result     want;
    } t_stim_row;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic [swrv_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [swrv_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;

    // Predictor's own copy of the stack; index 0 is the bottom.
    logic [31:0] stack_vals [swrv_pkg::STACK_DEPTH];
    int          stack_fill;

    t_result     pending_results [$];
    t_stim_row   directed_rows [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int err_count       = 0;
    int words_sent      = 0;
    int results_seen    = 0;
    int refused_pushes  = 0;
    int remove_hits     = 0;
    int remove_misses   = 0;
    int empty_pops      = 0;
    int peak_fill       = 0;

    stack_with_remove_by_value u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #1 i_clk = ~i_clk;

    // Stack behaviour: apply one operation to the predictor state and
    // return the result word the block should produce for it.
    function automatic t_result apply_stack_op(input logic [1:0] op,
                                               input logic [31:0] val);
        t_result res;
        bit      found;
        int      idx;
        res   = '0;
        found = 1'b0;
        if (op == swrv_pkg::OP_PUSH) begin
            if (stack_fill < swrv_pkg::STACK_DEPTH) begin
                stack_vals[stack_fill] = val;
                stack_fill++;
                res.ok = 1'b1;
            end else begin
                res.drop = 1'b1;
                refused_pushes++;
            end
        end else if (op == swrv_pkg::OP_POP) begin
            if (stack_fill > 0) begin
                stack_fill--;
                res.popped = stack_vals[stack_fill];
                res.ok     = 1'b1;
            end else begin
                empty_pops++;
            end
        end else if (op == swrv_pkg::OP_REMOVE) begin
            // search from the top; the first match goes, those above it
            // slide down one place
            for (idx = stack_fill - 1; idx >= 0 && !found; idx--) begin
                if (stack_vals[idx] == val) begin
                    for (int k = idx; k + 1 < stack_fill; k++)
                        stack_vals[k] = stack_vals[k + 1];
                    stack_fill--;
                    found = 1'b1;
                end
            end
            res.ok = found;
            if (found)
                remove_hits++;
            else
                remove_misses++;
        end
        res.count = stack_fill[4:0];
        if (stack_fill > peak_fill)
            peak_fill = stack_fill;
        return res;
    endfunction

    // Operand choice: small values give duplicates, removes mostly aim at
    // values that are actually held so the shift path gets exercised.
    function automatic logic [31:0] pick_operand(input logic [1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == swrv_pkg::OP_PUSH) begin
            if (r < 40)
                return $urandom;
            if (r < 50) begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            return 32'($signed($urandom_range(0, 6)) - 3);
        end
        if (op == swrv_pkg::OP_REMOVE) begin
            if (stack_fill > 0 && r < 60)
                return stack_vals[$urandom_range(0, stack_fill - 1)];
            if (r < 80)
                return 32'($signed($urandom_range(0, 6)) - 3);
        end
        return $urandom;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [31:0] val,
                                    input int reps, input bit hand_checked,
                                    input t_result want);
        t_stim_row row;
        row.op           = op;
        row.val          = val;
        row.reps         = reps[4:0];
        row.hand_checked = hand_checked;
        row.want         = want;
        directed_rows.push_back(row);
    endfunction

    // Offer one word on the input stream and hold it until taken. The
    // expected result is queued at the edge where the word is accepted.
    // Called and left at a falling edge; tvalid stays high between
    // back-to-back words and only drops for an idle gap.
    task automatic send_word(input logic [1:0] op, input logic [31:0] val,
                             input bit hand_checked, input t_result want);
        t_result pred;
        s_axis_tdata  <= {{(swrv_pkg::IN_TDATA_W - 34){1'b0}}, val, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pred = apply_stack_op(op, val);
        pending_results.push_back(hand_checked ? want : pred);
        words_sent++;
        @(negedge i_clk);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    // Output side back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Result checker: every word taken from m_axis is matched against the
    // oldest outstanding expectation, field by field.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.popped = m_axis_tdata[31:0];
            got.ok     = m_axis_tdata[32];
            got.drop   = m_axis_tdata[33];
            got.count  = m_axis_tdata[38:34];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.popped !== want.popped) begin
                    $error("popped_value: expected %0d, got %0d",
                           $signed(want.popped), $signed(got.popped));
                    err_count++;
                end
                if (got.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, got.ok);
                    err_count++;
                end
                if (got.drop !== want.drop) begin
                    $error("full_drop: expected %0d, got %0d", want.drop, got.drop);
                    err_count++;
                end
                if (got.count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    err_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, three random phases, drain.
    initial begin : stimulus
        t_stim_row   row;
        logic [1:0]  op;
        logic [31:0] val;
        bit          filling;
        int          mode_left;
        int          r;

        filling    = 1'b0;
        mode_left  = 0;
        stack_fill = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table. Hand-written results: fields are
        // popped_value, ok, full_drop, entry_count.
        add_row(swrv_pkg::OP_POP,    32'd0,         1,  1,
                '{32'd0, 1'b0, 1'b0, 5'd0});   // pop on empty
        add_row(swrv_pkg::OP_REMOVE, 32'd5,         1,  1,
                '{32'd0, 1'b0, 1'b0, 5'd0});   // remove on empty
        add_row(OP_NOP,              32'hFFFF_FFFF, 1,  1,
                '{32'd0, 1'b0, 1'b0, 5'd0});   // unused opcode
        add_row(swrv_pkg::OP_PUSH,   32'h8000_0000, 1,  1,
                '{32'd0, 1'b1, 1'b0, 5'd1});   // most negative
        add_row(swrv_pkg::OP_PUSH,   32'h7FFF_FFFF, 1,  1,
                '{32'd0, 1'b1, 1'b0, 5'd2});   // most positive
        add_row(swrv_pkg::OP_PUSH,   32'd7,         1,  0, '0);
        add_row(swrv_pkg::OP_PUSH,   32'd9,         1,  0, '0);
        add_row(swrv_pkg::OP_PUSH,   32'd7,         1,  0, '0);  // duplicate of a lower entry
        add_row(swrv_pkg::OP_PUSH,   32'd0,         11, 0, '0);  // fills the stack
        add_row(swrv_pkg::OP_PUSH,   32'hFFFF_FFFF, 1,  1,
                '{32'd0, 1'b0, 1'b1, 5'd16});  // full: dropped
        add_row(swrv_pkg::OP_REMOVE, 32'h8000_0000, 1,  0, '0);  // bottom entry, match chain runs the whole row
        add_row(swrv_pkg::OP_REMOVE, 32'd7,         1,  0, '0);  // only the upper 7 goes
        add_row(swrv_pkg::OP_REMOVE, 32'd123,       1,  0, '0);  // no match on a busy stack
        add_row(OP_NOP,              32'd0,         1,  0, '0);
        add_row(swrv_pkg::OP_POP,    32'd0,         1,  0, '0);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            repeat (row.reps)
                send_word(row.op, row.val, row.hand_checked, row.want);
        end

        // Random phases: idling first on the input side lightly and the
        // output heavily, then the other way round, then none at all.
        // Within a phase the mix swings between filling and draining runs so
        // both the full and the empty ends are reached repeatedly.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 64 : 0;
            rx_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 33 : 0;
            for (int i = 0; i < RAND_WORDS_PER_PHASE; i++) begin
                if (mode_left == 0) begin
                    filling   = !filling;
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                r = $urandom_range(0, 99);
                if (filling)
                    op = (r < 65) ? swrv_pkg::OP_PUSH : (r < 75) ? swrv_pkg::OP_POP :
                         (r < 95) ? swrv_pkg::OP_REMOVE : OP_NOP;
                else
                    op = (r < 15) ? swrv_pkg::OP_PUSH : (r < 60) ? swrv_pkg::OP_POP :
                         (r < 95) ? swrv_pkg::OP_REMOVE : OP_NOP;
                val = pick_operand(op);
                send_word(op, val, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words / %0d results, peak fill %0d, %0d refused pushes",
                 words_sent, results_seen, peak_fill, refused_pushes);
        $display("removes: %0d hit, %0d missed; pops on empty: %0d",
                 remove_hits, remove_misses, empty_pops);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run under full back-pressure.
    initial begin
        #400000;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
